// ===== design/rif_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package rif_pkg;

   // default sizing
   localparam int DEF_STACK_DEPTH     = 128;
   localparam int DEF_MAX_PATTERN_LEN = 4096;
   localparam int DEF_MAX_ALTERNATES  = 31;

   // operator bytes
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_PLUS   = 8'h2B;
   localparam logic [7:0] CH_QMARK  = 8'h3F;
   localparam logic [7:0] CH_BAR    = 8'h7C;

   typedef enum logic [2:0] {
      TK_LIT  = 3'd0,
      TK_CAT  = 3'd1,
      TK_ALT  = 3'd2,
      TK_STAR = 3'd3,
      TK_PLUS = 3'd4,
      TK_OPT  = 3'd5,
      TK_END  = 3'd6
   } token_kind_type;

   typedef enum logic [2:0] {
      ST_OK     = 3'd0,
      ST_SYNTAX = 3'd1,
      ST_NEST   = 3'd2,
      ST_LONG   = 3'd3,
      ST_ALTS   = 3'd4
   } status_type;

   // request class after decode
   typedef enum logic [2:0] {
      OP_LIT,
      OP_OPEN,
      OP_CLOSE,
      OP_BAR,
      OP_STAR,
      OP_PLUS,
      OP_OPT,
      OP_END
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [7:0] ch;
   } entry_type;

endpackage

`default_nettype wire

// ===== design/rif_channels.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface rif_req_if;
   logic       valid;
   logic       ready;
   logic       command;
   logic [7:0] pattern_char;

   modport source (output valid, output command, output pattern_char, input ready);
   modport sink   (input valid, input command, input pattern_char, output ready);
endinterface

interface rif_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] token_kind;
   logic [7:0] literal_char;
   logic [2:0] status;
   logic       last_of_run;

   modport source (output valid, output token_kind, output literal_char, output status,
                   output last_of_run, input ready);
   modport sink   (input valid, input token_kind, input literal_char, input status,
                   input last_of_run, output ready);
endinterface

`default_nettype wire

// ===== design/rif_classify.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rif_classify (
   rif_req_if.sink             req_ch,
   output logic                push_valid,
   output rif_pkg::entry_type  push_entry,
   input  logic                push_ready
);
   import rif_pkg::*;

   assign push_valid   = req_ch.valid;
   assign req_ch.ready = push_ready;

   always_comb begin
      push_entry.ch = req_ch.pattern_char;
      if (req_ch.command) begin
         push_entry.op = OP_END;
      end else begin
         case (req_ch.pattern_char)
            CH_LPAREN: push_entry.op = OP_OPEN;
            CH_RPAREN: push_entry.op = OP_CLOSE;
            CH_BAR:    push_entry.op = OP_BAR;
            CH_STAR:   push_entry.op = OP_STAR;
            CH_PLUS:   push_entry.op = OP_PLUS;
            CH_QMARK:  push_entry.op = OP_OPT;
            default:   push_entry.op = OP_LIT;
         endcase
      end
   end

endmodule

`default_nettype wire

// ===== design/rif_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rif_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   output logic                push_ready,
   input  rif_pkg::entry_type  push_entry,
   output logic                pop_valid,
   input  logic                pop_ready,
   output rif_pkg::entry_type  pop_entry
);
   import rif_pkg::*;

   // two-entry ring
   entry_type   slot_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff, count_in;
   logic        push, pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_entry  = slot_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

// ===== design/rif_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rif_back #(
   parameter int STACK_DEPTH     = rif_pkg::DEF_STACK_DEPTH,
   parameter int MAX_PATTERN_LEN = rif_pkg::DEF_MAX_PATTERN_LEN,
   parameter int MAX_ALTERNATES  = rif_pkg::DEF_MAX_ALTERNATES
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_valid,
   output logic                q_ready,
   input  rif_pkg::entry_type  q_entry,
   rif_rsp_if.source           rsp_ch
);
   import rif_pkg::*;

   localparam int ALT_W  = $clog2(MAX_ALTERNATES + 1);
   localparam int LVL_W  = $clog2(STACK_DEPTH + 1);
   localparam int IDX_W  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int CHAR_W = $clog2(MAX_PATTERN_LEN);

   typedef struct packed {
      logic [ALT_W-1:0] alts;
      logic [1:0]       atoms;
   } saved_type;

   typedef enum logic [1:0] {S_IDLE, S_RUN, S_POP} state_type;

   // group stack
   saved_type  stack_mem [STACK_DEPTH];
   saved_type  rd_data_ff;
   saved_type  wr_data;
   logic       mem_we;

   state_type        state_ff, state_in;
   logic [ALT_W-1:0] alt_count_ff, alt_count_in;
   logic [1:0]       atom_count_ff, atom_count_in;
   logic [LVL_W-1:0] stack_level_ff, stack_level_in;
   logic [CHAR_W-1:0] char_count_ff, char_count_in;
   status_type       err_ff, err_in;

   // pending emissions of the request in progress
   logic             cat_pend_ff, cat_pend_in;
   logic [ALT_W-1:0] alt_left_ff, alt_left_in;
   logic             fin_pend_ff, fin_pend_in;
   token_kind_type   fin_kind_ff, fin_kind_in;
   logic [7:0]       fin_char_ff, fin_char_in;
   status_type       fin_status_ff, fin_status_in;
   logic             pop_pend_ff, pop_pend_in;

   // output register
   logic             rsp_valid_ff, rsp_valid_in;
   token_kind_type   rsp_kind_ff, rsp_kind_in;
   logic [7:0]       rsp_char_ff, rsp_char_in;
   status_type       rsp_status_ff, rsp_status_in;
   logic             rsp_last_ff, rsp_last_in;

   logic             out_free;
   logic             has_job;
   logic             emit;
   status_type       end_st;

   assign q_ready             = (state_ff == S_IDLE);
   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.token_kind   = rsp_kind_ff;
   assign rsp_ch.literal_char = rsp_char_ff;
   assign rsp_ch.status       = rsp_status_ff;
   assign rsp_ch.last_of_run  = rsp_last_ff;

   assign out_free = !rsp_valid_ff || rsp_ch.ready;
   assign has_job  = cat_pend_ff || (alt_left_ff != '0) || fin_pend_ff;

   always_comb begin
      state_in       = state_ff;
      alt_count_in   = alt_count_ff;
      atom_count_in  = atom_count_ff;
      stack_level_in = stack_level_ff;
      char_count_in  = char_count_ff;
      err_in         = err_ff;
      cat_pend_in    = cat_pend_ff;
      alt_left_in    = alt_left_ff;
      fin_pend_in    = fin_pend_ff;
      fin_kind_in    = fin_kind_ff;
      fin_char_in    = fin_char_ff;
      fin_status_in  = fin_status_ff;
      pop_pend_in    = pop_pend_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ch.ready;
      rsp_kind_in    = rsp_kind_ff;
      rsp_char_in    = rsp_char_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_last_in    = rsp_last_ff;
      mem_we         = 1'b0;
      wr_data.alts   = alt_count_ff;
      wr_data.atoms  = (atom_count_ff > 2'd1) ? 2'd1 : atom_count_ff;
      emit           = 1'b0;
      end_st         = err_ff;

      case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               cat_pend_in   = 1'b0;
               alt_left_in   = '0;
               fin_pend_in   = 1'b0;
               fin_kind_in   = TK_LIT;
               fin_char_in   = 8'd0;
               fin_status_in = ST_OK;
               pop_pend_in   = 1'b0;
               if (q_entry.op == OP_END) begin
                  if (err_ff == ST_OK && (stack_level_ff != '0 || atom_count_ff == 2'd0)) begin
                     end_st = ST_SYNTAX;
                  end
                  if (end_st == ST_OK) begin
                     cat_pend_in = (atom_count_ff > 2'd1);
                     alt_left_in = alt_count_ff;
                  end
                  fin_pend_in    = 1'b1;
                  fin_kind_in    = TK_END;
                  fin_status_in  = end_st;
                  alt_count_in   = '0;
                  atom_count_in  = 2'd0;
                  stack_level_in = '0;
                  char_count_in  = '0;
                  err_in         = ST_OK;
               end else if (err_ff != ST_OK) begin
                  // error latched: drop bytes until the end request
               end else if (char_count_ff >= CHAR_W'(MAX_PATTERN_LEN - 1)) begin
                  err_in = ST_LONG;
               end else begin
                  char_count_in = char_count_ff + 1'b1;
                  case (q_entry.op)
                     OP_OPEN: begin
                        if (stack_level_ff >= LVL_W'(STACK_DEPTH)) begin
                           err_in = ST_NEST;
                        end else begin
                           cat_pend_in    = (atom_count_ff > 2'd1);
                           mem_we         = 1'b1;
                           stack_level_in = stack_level_ff + 1'b1;
                           alt_count_in   = '0;
                           atom_count_in  = 2'd0;
                        end
                     end
                     OP_CLOSE: begin
                        if (stack_level_ff == '0 || atom_count_ff == 2'd0) begin
                           err_in = ST_SYNTAX;
                        end else begin
                           cat_pend_in    = (atom_count_ff > 2'd1);
                           alt_left_in    = alt_count_ff;
                           stack_level_in = stack_level_ff - 1'b1;
                           pop_pend_in    = 1'b1;
                        end
                     end
                     OP_BAR: begin
                        if (atom_count_ff == 2'd0) begin
                           err_in = ST_SYNTAX;
                        end else if (alt_count_ff >= ALT_W'(MAX_ALTERNATES)) begin
                           err_in = ST_ALTS;
                        end else begin
                           cat_pend_in   = (atom_count_ff > 2'd1);
                           atom_count_in = 2'd0;
                           alt_count_in  = alt_count_ff + 1'b1;
                        end
                     end
                     OP_STAR, OP_PLUS, OP_OPT: begin
                        if (atom_count_ff == 2'd0) begin
                           err_in = ST_SYNTAX;
                        end else begin
                           fin_pend_in = 1'b1;
                           case (q_entry.op)
                              OP_STAR: fin_kind_in = TK_STAR;
                              OP_PLUS: fin_kind_in = TK_PLUS;
                              default: fin_kind_in = TK_OPT;
                           endcase
                        end
                     end
                     default: begin
                        cat_pend_in   = (atom_count_ff > 2'd1);
                        fin_pend_in   = 1'b1;
                        fin_kind_in   = TK_LIT;
                        fin_char_in   = q_entry.ch;
                        atom_count_in = (atom_count_ff > 2'd1) ? 2'd2 : atom_count_ff + 2'd1;
                     end
                  endcase
               end
               if (cat_pend_in || alt_left_in != '0 || fin_pend_in || pop_pend_in) begin
                  state_in = S_RUN;
               end
            end
         end
         S_RUN: begin
            if (!has_job) begin
               state_in = pop_pend_ff ? S_POP : S_IDLE;
            end else if (out_free) begin
               emit          = 1'b1;
               rsp_char_in   = 8'd0;
               rsp_status_in = ST_OK;
               if (cat_pend_ff) begin
                  rsp_kind_in = TK_CAT;
                  rsp_last_in = (alt_left_ff == '0) && !fin_pend_ff;
                  cat_pend_in = 1'b0;
               end else if (alt_left_ff != '0) begin
                  rsp_kind_in = TK_ALT;
                  rsp_last_in = (alt_left_ff == ALT_W'(1)) && !fin_pend_ff;
                  alt_left_in = alt_left_ff - 1'b1;
               end else begin
                  rsp_kind_in   = fin_kind_ff;
                  rsp_char_in   = fin_char_ff;
                  rsp_status_in = fin_status_ff;
                  rsp_last_in   = 1'b1;
                  fin_pend_in   = 1'b0;
               end
               if (rsp_last_in) begin
                  state_in = pop_pend_ff ? S_POP : S_IDLE;
               end
            end
         end
         S_POP: begin
            // read data settled: restore the outer group's counts
            alt_count_in  = rd_data_ff.alts;
            atom_count_in = rd_data_ff.atoms + 2'd1;
            pop_pend_in   = 1'b0;
            state_in      = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (emit) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         alt_count_ff   <= '0;
         atom_count_ff  <= 2'd0;
         stack_level_ff <= '0;
         char_count_ff  <= '0;
         err_ff         <= ST_OK;
         cat_pend_ff    <= 1'b0;
         alt_left_ff    <= '0;
         fin_pend_ff    <= 1'b0;
         pop_pend_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         alt_count_ff   <= alt_count_in;
         atom_count_ff  <= atom_count_in;
         stack_level_ff <= stack_level_in;
         char_count_ff  <= char_count_in;
         err_ff         <= err_in;
         cat_pend_ff    <= cat_pend_in;
         alt_left_ff    <= alt_left_in;
         fin_pend_ff    <= fin_pend_in;
         pop_pend_ff    <= pop_pend_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      fin_kind_ff   <= fin_kind_in;
      fin_char_ff   <= fin_char_in;
      fin_status_ff <= fin_status_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_char_ff   <= rsp_char_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
   end

   // stack: write at the current level, registered read of the top entry
   always_ff @(posedge clock) begin
      if (mem_we) begin
         stack_mem[stack_level_ff[IDX_W-1:0]] <= wr_data;
      end
      rd_data_ff <= stack_mem[stack_level_ff[IDX_W-1:0]];
   end

   a_atom_range: assert property (@(posedge clock) disable iff (reset)
      atom_count_ff != 2'd3)
      else $error("atom count out of range");

   a_level_range: assert property (@(posedge clock) disable iff (reset)
      stack_level_ff <= LVL_W'(STACK_DEPTH) && alt_count_ff <= ALT_W'(MAX_ALTERNATES))
      else $error("group level or alternation count beyond limit");

   a_pop_after_run: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_POP |-> $past(state_ff) == S_RUN)
      else $error("stack restore without a read cycle");

   a_err_sticky: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && q_valid && q_entry.op != OP_END && err_ff != ST_OK)
      |=> err_ff == $past(err_ff))
      else $error("latched error changed before end request");

   a_end_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_kind_ff == TK_END) |-> rsp_last_ff)
      else $error("end token not marked last");

endmodule

`default_nettype wire

// ===== design/regex_infix_to_postfix_unit.sv =====
// Regex infix-to-postfix converter.
// req_ch: one request per pattern byte (command 0) or an end request (command 1).
//   Operators are ( ) | * + ?; every other byte is a literal.
// rsp_ch: postfix tokens (literal, concat, alternate, star, plus, optional, end);
//   last_of_run marks the final token a request produces. A request may produce
//   none (error latched, operator with nothing to emit) or up to 33 tokens.
// Both channels are valid/ready; a transfer happens when both are high.
// Sequence: a request is first decoded, then its tokens are emitted one after
//   another; a closing group then restores counts from the group stack. The
//   single token engine of the back end sets the rate; a 2-entry queue in front
//   keeps accepting while it works.
// A request passes the queue and the decode step before its first token is registered.
// A stalled receiver holds the output register; the back end waits, the queue
//   fills and req_ch.ready then drops. No token is dropped or repeated.
// After an error, bytes are swallowed until the end request, which reports status.
// The end request returns all counters to the reset state.
// Reset (synchronous, active high) clears counters, queue and output valid;
//   the group stack needs no clearing since only pushed entries are read.
`timescale 1ns / 1ps
`default_nettype none

module regex_infix_to_postfix_unit #(
   parameter int STACK_DEPTH     = rif_pkg::DEF_STACK_DEPTH,
   parameter int MAX_PATTERN_LEN = rif_pkg::DEF_MAX_PATTERN_LEN,
   parameter int MAX_ALTERNATES  = rif_pkg::DEF_MAX_ALTERNATES
) (
   input  logic       clock,
   input  logic       reset,
   rif_req_if.sink    req_ch,
   rif_rsp_if.source  rsp_ch
);
   import rif_pkg::*;

   // front end: classify and enqueue
   logic       push_valid;
   logic       push_ready;
   entry_type  push_entry;

   // back end: pull from queue
   logic       pop_valid;
   logic       pop_ready;
   entry_type  pop_entry;

   rif_classify u_classify (
      .req_ch     (req_ch),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .push_ready (push_ready)
   );

   rif_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_entry  (pop_entry)
   );

   rif_back #(
      .STACK_DEPTH     (STACK_DEPTH),
      .MAX_PATTERN_LEN (MAX_PATTERN_LEN),
      .MAX_ALTERNATES  (MAX_ALTERNATES)
   ) u_back (
      .clock   (clock),
      .reset   (reset),
      .q_valid (pop_valid),
      .q_ready (pop_ready),
      .q_entry (pop_entry),
      .rsp_ch  (rsp_ch)
   );

endmodule

`default_nettype wire
